// ===== src/assert_macros.svh =====
// Assertion macros used by the frame table RTL.
// With SYNTH defined every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/ppft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppft_pkg
// Sizes, codes and types of the paged process frame table.
// ----------------------------------------------------------------------------
package ppft_pkg;

    localparam int MAX_PROCS     = 8;
    localparam int MAX_PAGES     = 16;
    localparam int FRAMES        = 32;
    localparam int MAX_PAGE_SIZE = 4096;

    localparam int OPCODE_W   = 3;
    localparam int PROC_W     = $clog2(MAX_PROCS);
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int OFFSET_W   = $clog2(MAX_PAGE_SIZE);
    localparam int HELD_W     = $clog2(MAX_PAGES + 1);
    localparam int COUNT_W    = HELD_W;
    localparam int TOTAL_W    = $clog2(MAX_PROCS + 1);
    localparam int PSIZE_W    = $clog2(MAX_PAGE_SIZE) + 1;
    localparam int TFRAMES_W  = 6;
    localparam int STATUS_W   = 3;
    localparam int VALUE_W    = 17;
    localparam int MAP_AW     = PROC_W + PAGE_W;
    localparam int MAP_DEPTH  = MAX_PROCS * MAX_PAGES;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PSIZE_W;
    localparam int ALU_W      = 18;

    localparam logic [PSIZE_W-1:0]   PAGE_SIZE_RST    = PSIZE_W'(1024);
    localparam logic [TFRAMES_W-1:0] TOTAL_FRAMES_RST = TFRAMES_W'(32);

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE = 3'd0,
        OP_SET    = 3'd1,
        OP_TERM   = 3'd2,
        OP_XLATE  = 3'd3,
        OP_STATUS = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_PROC   = 3'd1,
        ST_BAD_PAGE   = 3'd2,
        ST_MEM_FULL   = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SIZE    = 1'd0,
        CFG_TOTAL_FRAMES = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FREE,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [ALU_W-1:0]     a;
        logic [PSIZE_W-1:0]   b;
        logic [ALU_W-1:0]     c;
    } t_alu_req;

    // Frames actually usable: the register clipped to the physical count.
    function automatic logic [TFRAMES_W-1:0] eff_frames(input logic [TFRAMES_W-1:0] tf);
        logic [TFRAMES_W-1:0] lim;
        lim = TFRAMES_W'(FRAMES);
        return (tf > lim) ? lim : tf;
    endfunction

endpackage

// ===== src/ppft_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppft_in_if
// Request channel: opcode and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppft_in_if;
    logic                           valid;
    logic                           ready;
    logic [ppft_pkg::OPCODE_W-1:0]  opcode;
    logic [ppft_pkg::PROC_W-1:0]    process;
    logic [ppft_pkg::PAGE_W-1:0]    page;
    logic [ppft_pkg::FRAME_W-1:0]   frame;
    logic [ppft_pkg::OFFSET_W-1:0]  offset;
    logic [ppft_pkg::COUNT_W-1:0]   count;

    modport source (output valid, opcode, process, page, frame, offset, count, input ready);
    modport sink   (input valid, opcode, process, page, frame, offset, count, output ready);
endinterface

// ===== src/ppft_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppft_out_if
// Response channel: status and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppft_out_if;
    logic                           valid;
    logic                           ready;
    logic [ppft_pkg::STATUS_W-1:0]  status;
    logic [ppft_pkg::VALUE_W-1:0]   value;

    modport source (output valid, status, value, input ready);
    modport sink   (input valid, status, value, output ready);
endinterface

// ===== src/ppft_map_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppft_map_mem
// Page-to-frame map: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppft_map_mem (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ppft_pkg::MAP_AW-1:0]     i_waddr,
    input  logic [ppft_pkg::FRAME_W-1:0]    i_wdata,
    input  logic [ppft_pkg::MAP_AW-1:0]     i_raddr,
    output logic [ppft_pkg::FRAME_W-1:0]    o_rdata
);

    logic [ppft_pkg::FRAME_W-1:0] r_mem [ppft_pkg::MAP_DEPTH];
    logic [ppft_pkg::FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ppft_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppft_alu
// Shared arithmetic unit: add, subtract, multiply-add.
// ----------------------------------------------------------------------------
module ppft_alu (
    input  ppft_pkg::t_alu_req          i_req,
    output logic [ppft_pkg::ALU_W-1:0]  o_res
);

    localparam int PROD_W = ppft_pkg::ALU_W + ppft_pkg::PSIZE_W;

    logic [PROD_W-1:0] prod;

    always_comb begin
        prod = PROD_W'(i_req.a) * PROD_W'(i_req.b);
        case (i_req.op)
            ppft_pkg::ALU_ADD: o_res = i_req.a + i_req.c;
            ppft_pkg::ALU_SUB: o_res = i_req.a - i_req.c;
            ppft_pkg::ALU_MAC: o_res = ppft_pkg::ALU_W'(prod) + i_req.c;
            default:           o_res = '0;
        endcase
    end

endmodule

// ===== src/paged_process_frame_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_process_frame_table
// Per-process page tables, frame-in-use map and address translation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   opcode process page frame offset count
//  o_out     out  valid/ready   status value
//  i_cfg_*   in   write enable  idx 0 page_size, idx 1 total_frames
//
//  Create, set, status and every refused request go from execute to done;
//  a translate passes the multiply state too (map read, then multiply-add
//  in the ALU). Terminate walks the pages held, clearing one frame mark per
//  cycle through the single map read port. One request in flight at a time;
//  the output register holds a finished result while the next transfer is
//  taken. Synchronous active-low reset; the page map is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module paged_process_frame_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ppft_in_if.sink                             i_in,
    ppft_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [ppft_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppft_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PROC_W    = ppft_pkg::PROC_W;
    localparam int PAGE_W    = ppft_pkg::PAGE_W;
    localparam int FRAME_W   = ppft_pkg::FRAME_W;
    localparam int HELD_W    = ppft_pkg::HELD_W;
    localparam int TOTAL_W   = ppft_pkg::TOTAL_W;
    localparam int FREE_W    = ppft_pkg::TFRAMES_W;
    localparam int ALU_W     = ppft_pkg::ALU_W;
    localparam int VALUE_W   = ppft_pkg::VALUE_W;
    localparam int PSIZE_W   = ppft_pkg::PSIZE_W;

    // configuration
    logic [PSIZE_W-1:0]               r_page_size;
    logic [ppft_pkg::TFRAMES_W-1:0]   r_total_frames;

    // table state
    logic [TOTAL_W-1:0]               r_total, n_total;
    logic [HELD_W-1:0]                r_held [ppft_pkg::MAX_PROCS];
    logic [ppft_pkg::FRAMES-1:0]      r_in_use;
    logic [FREE_W-1:0]                r_free, n_free;

    // latched request
    ppft_pkg::t_op                    r_op;
    logic [PROC_W-1:0]                r_proc;
    logic [PAGE_W-1:0]                r_page;
    logic [FRAME_W-1:0]               r_frame;
    logic [ppft_pkg::OFFSET_W-1:0]    r_offset;
    logic [ppft_pkg::COUNT_W-1:0]     r_count;

    // sequencer
    ppft_pkg::t_state                 r_state, n_state;
    logic [PAGE_W-1:0]                r_idx, n_idx;
    ppft_pkg::t_status                r_res_status, n_res_status;
    logic [VALUE_W-1:0]               r_res_value, n_res_value;

    // output register
    logic                             r_out_valid;
    logic [ppft_pkg::STATUS_W-1:0]    r_out_status;
    logic [VALUE_W-1:0]               r_out_value;

    // strobes from the sequencer
    logic                             held_we;
    logic [PROC_W-1:0]                held_waddr;
    logic [HELD_W-1:0]                held_wdata;
    logic                             use_set;
    logic                             use_clr;
    logic [FRAME_W-1:0]               use_idx;
    logic                             map_we;
    logic [ppft_pkg::MAP_AW-1:0]      map_raddr;
    logic [FRAME_W-1:0]               map_rdata;
    logic                             out_load;

    ppft_pkg::t_alu_req               alu_req;
    logic [ALU_W-1:0]                 alu_res;

    logic                             accept;
    logic [HELD_W-1:0]                held_cur;
    logic [FREE_W-1:0]                eff;
    logic                             proc_ok;
    logic                             page_ok;
    logic                             frame_ok;
    logic                             off_ok;

    ppft_map_mem u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr ({r_proc, r_page}),
        .i_wdata (r_frame),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    ppft_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign i_in.ready   = (r_state == ppft_pkg::S_IDLE);
    assign accept       = i_in.valid && i_in.ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.value  = r_out_value;

    assign held_cur = r_held[r_proc];
    assign eff      = ppft_pkg::eff_frames(r_total_frames);
    assign proc_ok  = TOTAL_W'(r_proc) < r_total;
    assign page_ok  = HELD_W'(r_page) < held_cur;
    assign frame_ok = FREE_W'(r_frame) < eff;
    assign off_ok   = PSIZE_W'(r_offset) < r_page_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_free       = r_free;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        held_we      = 1'b0;
        held_waddr   = r_proc;
        held_wdata   = '0;
        use_set      = 1'b0;
        use_clr      = 1'b0;
        use_idx      = r_frame;
        map_we       = 1'b0;
        map_raddr    = {r_proc, r_page};
        out_load     = 1'b0;
        alu_req      = '{op: ppft_pkg::ALU_ADD, a: '0, b: '0, c: '0};

        case (r_state)
            ppft_pkg::S_IDLE: begin
                map_raddr = {i_in.process, i_in.page};
                if (accept) begin
                    n_res_status = ppft_pkg::ST_OK;
                    n_res_value  = '0;
                    n_state      = ppft_pkg::S_EXEC;
                end
            end

            ppft_pkg::S_EXEC: begin
                n_state = ppft_pkg::S_DONE;
                case (r_op)
                    ppft_pkg::OP_CREATE: begin
                        alu_req.op = ppft_pkg::ALU_SUB;
                        alu_req.a  = ALU_W'(r_free);
                        alu_req.c  = ALU_W'(r_count);
                        if (r_total >= TOTAL_W'(ppft_pkg::MAX_PROCS)) begin
                            n_res_status = ppft_pkg::ST_TABLE_FULL;
                        end else if (r_count > ppft_pkg::COUNT_W'(ppft_pkg::MAX_PAGES)) begin
                            n_res_status = ppft_pkg::ST_BAD_PAGE;
                        end else begin
                            // slot is taken even when the frames run short
                            held_we     = 1'b1;
                            held_waddr  = r_total[PROC_W-1:0];
                            n_res_value = VALUE_W'(r_total);
                            n_total     = r_total + TOTAL_W'(1);
                            if (FREE_W'(r_count) > r_free) begin
                                n_res_status = ppft_pkg::ST_MEM_FULL;
                            end else begin
                                held_wdata = HELD_W'(r_count);
                                n_free     = FREE_W'(alu_res);
                            end
                        end
                    end
                    ppft_pkg::OP_SET: begin
                        if (!proc_ok) begin
                            n_res_status = ppft_pkg::ST_BAD_PROC;
                        end else if (!page_ok || !frame_ok) begin
                            n_res_status = ppft_pkg::ST_BAD_PAGE;
                        end else begin
                            map_we  = 1'b1;
                            use_set = 1'b1;
                        end
                    end
                    ppft_pkg::OP_TERM: begin
                        n_idx     = '0;
                        map_raddr = {r_proc, PAGE_W'(0)};
                        if (!proc_ok) begin
                            n_res_status = ppft_pkg::ST_BAD_PROC;
                        end else if (held_cur == '0) begin
                            n_state = ppft_pkg::S_FREE;
                        end else begin
                            n_state = ppft_pkg::S_WALK;
                        end
                    end
                    ppft_pkg::OP_XLATE: begin
                        if (!proc_ok) begin
                            n_res_status = ppft_pkg::ST_BAD_PROC;
                        end else if (!page_ok || !off_ok) begin
                            n_res_status = ppft_pkg::ST_BAD_PAGE;
                        end else begin
                            n_state = ppft_pkg::S_MUL;
                        end
                    end
                    ppft_pkg::OP_STATUS: begin
                        if (!frame_ok) begin
                            n_res_status = ppft_pkg::ST_BAD_PAGE;
                        end else begin
                            n_res_value = VALUE_W'(r_in_use[r_frame]);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ppft_pkg::S_WALK: begin
                // clear the mark of page r_idx, read ahead the next entry
                alu_req.op = ppft_pkg::ALU_ADD;
                alu_req.a  = ALU_W'(r_idx);
                alu_req.c  = ALU_W'(1);
                use_clr    = 1'b1;
                use_idx    = map_rdata;
                map_raddr  = {r_proc, alu_res[PAGE_W-1:0]};
                n_idx      = alu_res[PAGE_W-1:0];
                if (alu_res[HELD_W-1:0] == held_cur) begin
                    n_state = ppft_pkg::S_FREE;
                end
            end

            ppft_pkg::S_FREE: begin
                alu_req.op = ppft_pkg::ALU_ADD;
                alu_req.a  = ALU_W'(r_free);
                alu_req.c  = ALU_W'(held_cur);
                n_free     = (alu_res > ALU_W'(eff)) ? eff : FREE_W'(alu_res);
                held_we    = 1'b1;
                held_waddr = r_proc;
                held_wdata = '0;
                n_state    = ppft_pkg::S_DONE;
            end

            ppft_pkg::S_MUL: begin
                alu_req.op  = ppft_pkg::ALU_MAC;
                alu_req.a   = ALU_W'(map_rdata);
                alu_req.b   = r_page_size;
                alu_req.c   = ALU_W'(r_offset);
                n_res_value = alu_res[VALUE_W-1:0];
                n_state     = ppft_pkg::S_DONE;
            end

            ppft_pkg::S_DONE: begin
                // wait for the output register to drain
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ppft_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ppft_pkg::S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size    <= ppft_pkg::PAGE_SIZE_RST;
            r_total_frames <= ppft_pkg::TOTAL_FRAMES_RST;
            r_free         <= ppft_pkg::eff_frames(ppft_pkg::TOTAL_FRAMES_RST);
            r_total        <= '0;
            r_in_use       <= '0;
            for (int p = 0; p < ppft_pkg::MAX_PROCS; p++) begin
                r_held[p] <= '0;
            end
        end else begin
            r_total <= n_total;
            if (i_cfg_we && i_cfg_idx == ppft_pkg::CFG_TOTAL_FRAMES) begin
                r_total_frames <= i_cfg_data[ppft_pkg::TFRAMES_W-1:0];
                r_free         <= ppft_pkg::eff_frames(i_cfg_data[ppft_pkg::TFRAMES_W-1:0]);
            end else begin
                r_free <= n_free;
            end
            if (i_cfg_we && i_cfg_idx == ppft_pkg::CFG_PAGE_SIZE) begin
                r_page_size <= i_cfg_data;
            end
            if (held_we) begin
                r_held[held_waddr] <= held_wdata;
            end
            if (use_set) begin
                r_in_use[use_idx] <= 1'b1;
            end else if (use_clr) begin
                r_in_use[use_idx] <= 1'b0;
            end
        end
    end

    // request latch, walk index and result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= ppft_pkg::t_op'(i_in.opcode);
            r_proc   <= i_in.process;
            r_page   <= i_in.page;
            r_frame  <= i_in.frame;
            r_offset <= i_in.offset;
            r_count  <= i_in.count;
        end
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    `ASSERT_HOLDS(a_free_bound, i_clk, i_rst_n, r_free <= eff, "free frame count above usable frames")
    `ASSERT_HOLDS(a_total_bound, i_clk, i_rst_n, r_total <= TOTAL_W'(ppft_pkg::MAX_PROCS), "process count overflow")
    `ASSERT_IMPL(a_walk_idx, i_clk, i_rst_n, r_state == ppft_pkg::S_WALK, HELD_W'(r_idx) < held_cur, "terminate walk past pages held")
    `ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == ppft_pkg::S_DONE && (!r_out_valid || o_out.ready), r_out_valid && r_state == ppft_pkg::S_IDLE, "finished result not presented")

endmodule

// ===== verif/ppft_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppft_tb_pkg
// Request and response types plus a tracker that mirrors the frame table:
// it predicts the response of every accepted request and checks responses
// in order against those predictions.
// ----------------------------------------------------------------------------
package ppft_tb_pkg;

    import ppft_pkg::*;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PROC_W-1:0]   proc;
        logic [PAGE_W-1:0]   page;
        logic [FRAME_W-1:0]  frame;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
    } table_req_t;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] value;
    } table_resp_t;

    class frame_table_tracker;
        int unsigned page_size;
        int unsigned total_frames;
        int unsigned proc_total;
        int unsigned free_frames;
        int unsigned pages_held [MAX_PROCS];
        int unsigned frame_of [MAP_DEPTH];
        bit          map_written [MAP_DEPTH];
        bit          frame_used [FRAMES];
        table_resp_t due [$];
        int unsigned checked;
        int unsigned mismatches;

        function new();
            page_size    = PAGE_SIZE_RST;
            total_frames = TOTAL_FRAMES_RST;
            proc_total   = 0;
            checked      = 0;
            mismatches   = 0;
            foreach (pages_held[i]) pages_held[i] = 0;
            foreach (frame_of[i]) begin
                frame_of[i]    = 0;
                map_written[i] = 1'b0;
            end
            foreach (frame_used[i]) frame_used[i] = 1'b0;
            free_frames = usable_frames();
        endfunction

        function int unsigned usable_frames();
            return (total_frames > FRAMES) ? FRAMES : total_frames;
        endfunction

        function void write_reg(t_cfg_idx idx, int unsigned data);
            if (idx == CFG_PAGE_SIZE) begin
                page_size = data % (1 << PSIZE_W);
            end else begin
                total_frames = data % (1 << TFRAMES_W);
                free_frames  = usable_frames();
            end
        endfunction

        function void note_request(table_req_t r);
            t_status            st;
            logic [VALUE_W-1:0] val;
            int unsigned        slot;
            int unsigned        addr;
            st   = ST_OK;
            val  = '0;
            slot = r.proc * MAX_PAGES + r.page;
            case (r.opcode)
                OP_CREATE: begin
                    if (proc_total >= MAX_PROCS) begin
                        st = ST_TABLE_FULL;
                    end else if (r.count > MAX_PAGES) begin
                        st = ST_BAD_PAGE;
                    end else if (r.count > free_frames) begin
                        // slot is burned even though no frames are reserved
                        st = ST_MEM_FULL;
                        pages_held[proc_total] = 0;
                        val = VALUE_W'(proc_total);
                        proc_total++;
                    end else begin
                        pages_held[proc_total] = r.count;
                        free_frames -= r.count;
                        val = VALUE_W'(proc_total);
                        proc_total++;
                    end
                end
                OP_SET: begin
                    if (r.proc >= proc_total) begin
                        st = ST_BAD_PROC;
                    end else if (r.page >= pages_held[r.proc] || r.frame >= usable_frames()) begin
                        st = ST_BAD_PAGE;
                    end else begin
                        frame_of[slot]      = r.frame;
                        map_written[slot]   = 1'b1;
                        frame_used[r.frame] = 1'b1;
                    end
                end
                OP_TERM: begin
                    if (r.proc >= proc_total) begin
                        st = ST_BAD_PROC;
                    end else begin
                        for (int k = 0; k < pages_held[r.proc]; k++)
                            frame_used[frame_of[r.proc * MAX_PAGES + k]] = 1'b0;
                        free_frames += pages_held[r.proc];
                        if (free_frames > usable_frames()) free_frames = usable_frames();
                        pages_held[r.proc] = 0;
                    end
                end
                OP_XLATE: begin
                    if (r.proc >= proc_total) begin
                        st = ST_BAD_PROC;
                    end else if (r.page >= pages_held[r.proc] || r.offset >= page_size) begin
                        st = ST_BAD_PAGE;
                    end else begin
                        addr = frame_of[slot] * page_size + r.offset;
                        val  = VALUE_W'(addr);
                    end
                end
                OP_STATUS: begin
                    if (r.frame >= usable_frames()) st = ST_BAD_PAGE;
                    else val = VALUE_W'(frame_used[r.frame]);
                end
                default: ;
            endcase
            due.push_back('{status: st, value: val});
        endfunction

        function void check_response(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value);
            table_resp_t want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: response with nothing outstanding: status %0d value %0d",
                             status, value);
                return;
            end
            want = due.pop_front();
            checked++;
            if (status !== want.status || value !== want.value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: response %0d: status %0d (expected %0d), value %0d (expected %0d)",
                             checked, status, want.status, value, want.value);
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged process frame table. A short directed
// sequence hits all codes but table full, frame clipping, zero page size
// and address wrap; random traffic then runs under several register settings
// with random stalls on both channels, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_top;

    import ppft_pkg::*;
    import ppft_tb_pkg::*;

    localparam int          NUM_PHASES  = 7;
    localparam int          STUCK_LIMIT = 2000;
    localparam int          SETTLE      = 24;
    localparam int          LONG_HOLD   = 80;
    localparam int unsigned PH_PSIZE   [NUM_PHASES] = '{4096, 1, 0, 0, 8191, 8191, 1024};
    localparam int unsigned PH_TFRAMES [NUM_PHASES] = '{32, 1, 0, 63, 0, 20, 32};
    localparam int unsigned PH_ITEMS   [NUM_PHASES] = '{320, 200, 300, 150, 80, 170, 380};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ppft_in_if  in_if ();
    ppft_out_if out_if ();

    paged_process_frame_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    frame_table_tracker sb;

    logic        idling;
    int unsigned hold_asks  = 0;
    int unsigned hold_done  = 0;
    int unsigned rx_wait    = 0;
    int unsigned stuck      = 0;
    int unsigned n_sent     = 0;
    int unsigned n_settings = 0;
    bit          made_proc;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // no progress on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck <= 0;
        end else if (stuck == STUCK_LIMIT) begin
            $display("tb_top: no transfer for %0d cycles", STUCK_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // response side: check each transfer, then pick next cycle's ready
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                sb.check_response(out_if.status, out_if.value);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                rx_wait   = LONG_HOLD;
            end else if (rx_wait == 0 && idling && $urandom_range(0, 5) == 0) begin
                rx_wait = $urandom_range(1, 9);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic table_req_t mk(int unsigned op, int unsigned proc, int unsigned page,
                                      int unsigned frame, int unsigned offset,
                                      int unsigned count);
        table_req_t r;
        r.opcode = OPCODE_W'(op);
        r.proc   = PROC_W'(proc);
        r.page   = PAGE_W'(page);
        r.frame  = FRAME_W'(frame);
        r.offset = OFFSET_W'(offset);
        r.count  = COUNT_W'(count);
        return r;
    endfunction

    // Never read a map entry that was never written: redirect such a
    // translate or terminate into a set of the missing page.
    function automatic table_req_t keep_defined(table_req_t r);
        int unsigned held;
        int unsigned base;
        int unsigned usable;
        bit          moved;
        held   = sb.pages_held[r.proc];
        base   = r.proc * MAX_PAGES;
        usable = sb.usable_frames();
        moved  = 1'b0;
        if (r.proc < sb.proc_total) begin
            if (r.opcode == OP_XLATE && r.page < held && r.offset < sb.page_size
                && !sb.map_written[base + r.page]) begin
                r.opcode = OP_SET;
                moved    = 1'b1;
            end
            if (r.opcode == OP_TERM) begin
                for (int k = 0; k < held; k++) begin
                    if (!sb.map_written[base + k]) begin
                        r.opcode = OP_SET;
                        r.page   = PAGE_W'(k);
                        moved    = 1'b1;
                        break;
                    end
                end
            end
            if (moved && usable > 0) r.frame = FRAME_W'($urandom_range(0, usable - 1));
        end
        return r;
    endfunction

    function automatic table_req_t random_req();
        table_req_t  r;
        int unsigned pick;
        int unsigned held;
        int unsigned usable;
        int unsigned span;
        r      = table_req_t'($urandom());
        usable = sb.usable_frames();
        span   = (sb.page_size > MAX_PAGE_SIZE) ? MAX_PAGE_SIZE : sb.page_size;
        if (sb.proc_total > 0 && $urandom_range(0, 99) < 85)
            r.proc = PROC_W'($urandom_range(0, sb.proc_total - 1));
        held = sb.pages_held[r.proc];
        if (held > 0 && $urandom_range(0, 99) < 85)
            r.page = PAGE_W'($urandom_range(0, held - 1));
        if (usable > 0 && $urandom_range(0, 99) < 90)
            r.frame = FRAME_W'($urandom_range(0, usable - 1));
        if (span > 0 && $urandom_range(0, 99) < 85)
            r.offset = OFFSET_W'($urandom_range(0, span - 1));
        if ($urandom_range(0, 99) < 80)
            r.count = COUNT_W'($urandom_range(0, MAX_PAGES));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            // this branch spends at most one free process slot per phase
            if (sb.proc_total < MAX_PROCS && made_proc) begin
                r.opcode = OP_SET;
            end else begin
                r.opcode = OP_CREATE;
                if (sb.proc_total < MAX_PROCS) made_proc = 1'b1;
            end
        end else if (pick < 38) begin
            r.opcode = OP_SET;
        end else if (pick < 76) begin
            r.opcode = OP_XLATE;
        end else if (pick < 78) begin
            r.opcode = OP_TERM;
        end else if (pick < 93) begin
            r.opcode = OP_STATUS;
        end else begin
            r = table_req_t'($urandom());
        end
        return keep_defined(r);
    endfunction

    task automatic send_req(table_req_t r);
        if (idling && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.opcode  <= r.opcode;
        in_if.process <= r.proc;
        in_if.page    <= r.page;
        in_if.frame   <= r.frame;
        in_if.offset  <= r.offset;
        in_if.count   <= r.count;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned psize, int unsigned tframes);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PAGE_SIZE;
        i_cfg_data <= CFG_DATA_W'(psize);
        @(posedge i_clk);
        sb.write_reg(CFG_PAGE_SIZE, psize);
        i_cfg_idx  <= CFG_TOTAL_FRAMES;
        i_cfg_data <= CFG_DATA_W'(tframes);
        @(posedge i_clk);
        sb.write_reg(CFG_TOTAL_FRAMES, tframes);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int unsigned psize;
        int unsigned tframes;
        sb = new();
        idling        <= 1'b1;
        in_if.valid   <= 1'b0;
        in_if.opcode  <= '0;
        in_if.process <= '0;
        in_if.page    <= '0;
        in_if.frame   <= '0;
        in_if.offset  <= '0;
        in_if.count   <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PAGE_SIZE;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(1024, 32);
        send_req(mk(OP_XLATE, 0, 0, 0, 0, 0));          // no process yet
        send_req(mk(OP_STATUS, 0, 0, 0, 0, 0));
        send_req(mk(OP_CREATE, 0, 0, 0, 0, 2));
        send_req(mk(OP_CREATE, 0, 0, 0, 0, 17));        // too many pages
        send_req(mk(OP_CREATE, 0, 0, 0, 0, 16));
        send_req(mk(OP_CREATE, 0, 0, 0, 0, 15));        // not enough frames left
        send_req(mk(OP_SET, 0, 0, 0, 0, 0));
        send_req(mk(OP_SET, 0, 1, 31, 0, 0));
        send_req(mk(OP_SET, 0, 2, 3, 0, 0));
        send_req(mk(OP_SET, 1, 15, 5, 0, 0));
        send_req(mk(OP_SET, 2, 0, 0, 0, 0));
        send_req(mk(OP_XLATE, 0, 1, 0, 1023, 0));
        send_req(mk(OP_XLATE, 0, 1, 0, 1024, 0));
        send_req(mk(OP_XLATE, 1, 15, 0, 0, 0));
        send_req(mk(OP_XLATE, 3, 0, 0, 0, 0));
        send_req(mk(OP_STATUS, 0, 0, 31, 0, 0));
        send_req(mk(OP_STATUS, 0, 0, 1, 0, 0));
        send_req(mk(5, 0, 0, 0, 0, 0));
        send_req(mk(7, 7, 15, 31, 4095, 31));

        // frame count above the physical size, address wider than the port
        set_config(8191, 63);
        send_req(mk(OP_STATUS, 0, 0, 31, 0, 0));
        send_req(mk(OP_XLATE, 0, 1, 0, 4095, 0));
        send_req(mk(OP_SET, 1, 0, 31, 0, 0));
        send_req(mk(OP_TERM, 0, 0, 0, 0, 0));
        send_req(mk(OP_TERM, 0, 0, 0, 0, 0));

        // zero page size, single frame
        set_config(0, 1);
        send_req(mk(OP_XLATE, 1, 15, 0, 0, 0));
        send_req(mk(OP_SET, 1, 1, 1, 0, 0));
        send_req(mk(OP_STATUS, 0, 0, 1, 0, 0));
        send_req(mk(OP_STATUS, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            psize   = PH_PSIZE[ph];
            tframes = PH_TFRAMES[ph];
            if (ph == 2) begin
                psize   = $urandom_range(2, MAX_PAGE_SIZE - 1);
                tframes = $urandom_range(2, FRAMES - 1);
            end
            if (ph == NUM_PHASES - 1) idling <= 1'b0;
            set_config(psize, tframes);
            // keep slots for phases where frames are plentiful
            made_proc = (ph == 1 || ph == 4);
            for (int i = 0; i < PH_ITEMS[ph]; i++) begin
                if (ph == 0 && i == 100) hold_asks <= hold_asks + 1;
                if (ph == 2 && i == 150) wait_for_results();
                send_req(random_req());
            end
        end

        wait_for_results();
        $display("tb_top: %0d requests over %0d register settings, with random stalls,",
                 n_sent, n_settings);
        $display("tb_top: a long output hold and a full drain; %0d checked, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.due.size() != 0)
            $display("tb_top: %0d responses never arrived", sb.due.size());
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ppft_pkg.sv
src/ppft_in_if.sv
src/ppft_out_if.sv
src/ppft_map_mem.sv
src/ppft_alu.sv
src/paged_process_frame_table.sv
verif/ppft_tb_pkg.sv
verif/tb_top.sv
